FILE: rtl/bose_pkg.sv
// ----------------------------------------------------------------------------
// bose_pkg
// Shared types, request and status codes, and helpers of the bucket offset
// split encoder.
// ----------------------------------------------------------------------------
package bose_pkg;

    // Request codes.
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // The last bucket ends here.
    localparam logic [16:0] VALUE_LIMIT = 17'h10000;

    // Stream select codes.
    localparam logic SEL_INDEX  = 1'b0;
    localparam logic SEL_OFFSET = 1'b1;

    typedef struct packed {
        logic       stream_sel;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic [2:0] spare_index_bits;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [6:0] idx_bits;
        logic [2:0] idx_count;
        logic [6:0] off_bits;
        logic [2:0] off_count;
    } t_pending;

    typedef struct packed {
        logic       idx_has;
        logic [7:0] idx_byte;
        logic [1:0] off_num;
        logic [7:0] off_byte0;
        logic [7:0] off_byte1;
        t_pending   next;
    } t_pack;

    // Smallest b with 2**b not below n.
    function automatic logic [4:0] width_for(input logic [16:0] n);
        logic [4:0] w;
        w = '0;
        for (int i = 0; i < 17; i++) begin
            if ((17'd1 << i) < n) begin
                w = 5'(i + 1);
            end
        end
        return w;
    endfunction

    function automatic t_result mk_result(input logic       sel,
                                          input logic [7:0] data,
                                          input logic       valid,
                                          input logic [2:0] spare,
                                          input logic [1:0] status);
        t_result r;
        r.stream_sel       = sel;
        r.out_byte         = data;
        r.byte_valid       = valid;
        r.run_last         = 1'b0;
        r.spare_index_bits = spare;
        r.status           = status;
        return r;
    endfunction

endpackage

FILE: rtl/bose_in_if.sv
// ----------------------------------------------------------------------------
// bose_in_if
// Request channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface bose_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [15:0] entry_base;
    logic [15:0] sample_value;

    modport source (output valid, output req_type, output entry_index,
                    output entry_base, output sample_value, input ready);
    modport sink   (input valid, input req_type, input entry_index,
                    input entry_base, input sample_value, output ready);
endinterface

FILE: rtl/bose_out_if.sv
// ----------------------------------------------------------------------------
// bose_out_if
// Result channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface bose_out_if;
    logic       valid;
    logic       ready;
    logic       stream_sel;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic [2:0] spare_index_bits;
    logic [1:0] status;

    modport source (output valid, output stream_sel, output out_byte,
                    output byte_valid, output run_last,
                    output spare_index_bits, output status, input ready);
    modport sink   (input valid, input stream_sel, input out_byte,
                    input byte_valid, input run_last,
                    input spare_index_bits, input status, output ready);
endinterface

FILE: rtl/bose_cfg_if.sv
// ----------------------------------------------------------------------------
// bose_cfg_if
// Configuration write channel for the bucket count register.
// ----------------------------------------------------------------------------
interface bose_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] bucket_count;

    modport source (output valid, output bucket_count, input ready);
    modport sink   (input valid, input bucket_count, output ready);
endinterface

FILE: rtl/bucket_offset_split_encoder_top.sv
// ----------------------------------------------------------------------------
// bucket_offset_split_encoder_top
// Encodes 16-bit values as a bucket index and an offset from the bucket base,
// packed into two tagged byte streams.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake      Carries
//  i_in     in         valid / ready  req_type, entry_index, entry_base,
//                                     sample_value
//  i_cfg    in         valid / ready  bucket_count (always ready)
//  o_out    out        valid / ready  stream_sel, out_byte, byte_valid,
//                                     run_last, spare_index_bits, status
//
// One request at a time. An encode with an increasing table runs a binary
// search that makes one table read per cycle. With an unordered table the
// search scans down from the top entry, one read per cycle. The results of
// every request then pass one at a time through the output register. Reset
// is synchronous; the table has no clearing pass. A stalled result holds the
// output register and the sequencer until it is taken.
// ----------------------------------------------------------------------------
module bucket_offset_split_encoder_top import bose_pkg::*; #(
    parameter int MAX_BUCKETS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bose_in_if.sink   i_in,
    bose_cfg_if.sink  i_cfg,
    bose_out_if.source o_out
);

    localparam int LW = $clog2(MAX_BUCKETS);
    localparam int BW = (LW > 1) ? $clog2(LW) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LD_PREV  = 4'd1;
    localparam logic [3:0] S_LD_NEXT  = 4'd2;
    localparam logic [3:0] S_EN_BASE0 = 4'd3;
    localparam logic [3:0] S_EN_BIN   = 4'd4;
    localparam logic [3:0] S_EN_LIN   = 4'd5;
    localparam logic [3:0] S_EN_SPAN  = 4'd6;
    localparam logic [3:0] S_EN_PACK  = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [8:0]             r_count;
    logic [1:0]             r_req, n_req;
    logic [7:0]             r_idx, n_idx;
    logic [15:0]            r_base, n_base;
    logic [15:0]            r_val, n_val;
    logic [LW-1:0]          r_lo, n_lo;
    logic [15:0]            r_lo_base, n_lo_base;
    logic [LW-1:0]          r_cand, n_cand;
    logic [BW-1:0]          r_bit, n_bit;
    logic [15:0]            r_off, n_off;
    logic [4:0]             r_wo, n_wo;
    t_pending               r_pend, n_pend;
    t_result                r_res [3];
    t_result                n_res [3];
    logic [1:0]             r_num, n_num;
    logic [1:0]             r_ptr, n_ptr;
    t_result                r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    logic [15:0]            r_rdata;
    logic [15:0]            r_table [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_bad;
    logic                   r_unsorted;

    logic [8:0]             w_cnt;
    logic [8:0]             w_cnt_m1;
    logic [MAX_BUCKETS-1:0] w_in_use;
    logic [LW-1:0]          w_raddr;
    logic [7:0]             w_idx_m1;
    logic [LW-1:0]          w_nx_addr;
    logic                   w_take;
    logic [LW-1:0]          w_lo_new;
    logic [15:0]            w_lo_base_new;
    logic [16:0]            w_end;
    logic [16:0]            w_span;
    logic [4:0]             w_wi;
    t_pack                  w_pack;

    // A count of zero acts as one, a count above the table size as the size.
    always_comb begin
        if (r_count == 9'd0) begin
            w_cnt = 9'd1;
        end else if (r_count > 9'(MAX_BUCKETS)) begin
            w_cnt = 9'(MAX_BUCKETS);
        end else begin
            w_cnt = r_count;
        end
    end

    assign w_cnt_m1  = w_cnt - 9'd1;
    assign w_wi      = width_for(17'(w_cnt));
    assign w_idx_m1  = i_in.entry_index - 8'd1;
    assign w_nx_addr = r_idx[LW-1:0] + LW'(1);

    always_comb begin
        for (int i = 0; i < MAX_BUCKETS; i++) begin
            w_in_use[i] = (9'(i) < w_cnt);
        end
    end

    assign w_take        = (9'(r_cand) < w_cnt) && (r_rdata <= r_val);
    assign w_lo_new      = w_take ? r_cand : r_lo;
    assign w_lo_base_new = w_take ? r_rdata : r_lo_base;

    assign w_end  = ((9'(r_lo) + 9'd1) >= w_cnt) ? VALUE_LIMIT : 17'(r_rdata);
    assign w_span = w_end - 17'(r_lo_base);

    bose_packer u_packer (
        .i_pend         (r_pend),
        .i_sel          (8'(r_lo)),
        .i_sel_width    (w_wi[3:0]),
        .i_offset       (r_off),
        .i_offset_width (r_wo),
        .o_pack         (w_pack)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        logic [1:0] k;
        k           = 2'd0;
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_base      = r_base;
        n_val       = r_val;
        n_lo        = r_lo;
        n_lo_base   = r_lo_base;
        n_cand      = r_cand;
        n_bit       = r_bit;
        n_off       = r_off;
        n_wo        = r_wo;
        n_pend      = r_pend;
        n_res       = r_res;
        n_num       = r_num;
        n_ptr       = r_ptr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        w_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_req  = i_in.req_type;
                    n_idx  = i_in.entry_index;
                    n_base = i_in.entry_base;
                    n_val  = i_in.sample_value;
                    n_ptr  = 2'd0;
                    n_num  = 2'd1;
                    n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0, 3'd0, ST_OK);
                    case (i_in.req_type)
                        REQ_LOAD: begin
                            if (9'(i_in.entry_index) >= w_cnt) begin
                                n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0, 3'd0, ST_RANGE);
                                n_state  = S_EMIT;
                            end else if (i_in.entry_index == 8'd0) begin
                                w_raddr = LW'(1);
                                n_state = S_LD_NEXT;
                            end else begin
                                w_raddr = w_idx_m1[LW-1:0];
                                n_state = S_LD_PREV;
                            end
                        end
                        REQ_ENCODE: begin
                            w_raddr = '0;
                            n_state = S_EN_BASE0;
                        end
                        REQ_FINISH: begin
                            if (r_pend.idx_count != 3'd0) begin
                                n_res[k] = mk_result(SEL_INDEX, {1'b0, r_pend.idx_bits},
                                                     1'b1, 3'(3'd0 - r_pend.idx_count), ST_OK);
                                k = k + 2'd1;
                            end
                            if (r_pend.off_count != 3'd0) begin
                                n_res[k] = mk_result(SEL_OFFSET, {1'b0, r_pend.off_bits},
                                                     1'b1, 3'(3'd0 - r_pend.idx_count), ST_OK);
                                k = k + 2'd1;
                            end
                            if (k == 2'd0) begin
                                n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0,
                                                     3'(3'd0 - r_pend.idx_count), ST_OK);
                                k = 2'd1;
                            end
                            n_num   = k;
                            n_pend  = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_LD_PREV: begin
                if (r_base <= r_rdata) begin
                    n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0, 3'd0, ST_ORDER);
                    n_state  = S_EMIT;
                end else begin
                    w_raddr = w_nx_addr;
                    n_state = S_LD_NEXT;
                end
            end
            S_LD_NEXT: begin
                // Table write and order flag update happen in the clocked block.
                n_state = S_EMIT;
            end
            S_EN_BASE0: begin
                if (r_val < r_rdata) begin
                    n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0, 3'd0, ST_BELOW);
                    n_state  = S_EMIT;
                end else begin
                    n_lo      = '0;
                    n_lo_base = r_rdata;
                    if (r_unsorted) begin
                        n_cand  = w_cnt_m1[LW-1:0];
                        w_raddr = w_cnt_m1[LW-1:0];
                        n_state = S_EN_LIN;
                    end else begin
                        n_cand  = LW'(1) << (LW - 1);
                        w_raddr = LW'(1) << (LW - 1);
                        n_bit   = BW'(LW - 1);
                        n_state = S_EN_BIN;
                    end
                end
            end
            S_EN_BIN: begin
                n_lo      = w_lo_new;
                n_lo_base = w_lo_base_new;
                if (r_bit == '0) begin
                    w_raddr = w_lo_new + LW'(1);
                    n_state = S_EN_SPAN;
                end else begin
                    n_cand  = w_lo_new | (LW'(1) << (r_bit - BW'(1)));
                    w_raddr = w_lo_new | (LW'(1) << (r_bit - BW'(1)));
                    n_bit   = r_bit - BW'(1);
                end
            end
            S_EN_LIN: begin
                // The first base was already found not above the value, so
                // the downward scan always stops.
                if (r_rdata <= r_val) begin
                    n_lo      = r_cand;
                    n_lo_base = r_rdata;
                    w_raddr   = r_cand + LW'(1);
                    n_state   = S_EN_SPAN;
                end else begin
                    n_cand  = r_cand - LW'(1);
                    w_raddr = r_cand - LW'(1);
                end
            end
            S_EN_SPAN: begin
                n_wo    = width_for(w_span);
                n_off   = r_val - r_lo_base;
                n_state = S_EN_PACK;
            end
            S_EN_PACK: begin
                if (w_pack.idx_has) begin
                    n_res[k] = mk_result(SEL_INDEX, w_pack.idx_byte, 1'b1, 3'd0, ST_OK);
                    k = k + 2'd1;
                end
                if (w_pack.off_num != 2'd0) begin
                    n_res[k] = mk_result(SEL_OFFSET, w_pack.off_byte0, 1'b1, 3'd0, ST_OK);
                    k = k + 2'd1;
                end
                if (w_pack.off_num == 2'd2) begin
                    n_res[k] = mk_result(SEL_OFFSET, w_pack.off_byte1, 1'b1, 3'd0, ST_OK);
                    k = k + 2'd1;
                end
                if (k == 2'd0) begin
                    n_res[0] = mk_result(SEL_INDEX, 8'd0, 1'b0, 3'd0, ST_OK);
                    k = 2'd1;
                end
                n_num   = k;
                n_pend  = w_pack.next;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out          = r_res[r_ptr];
                    n_out.run_last = (r_ptr == r_num - 2'd1);
                    n_out_valid    = 1'b1;
                    if (r_ptr == r_num - 2'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = r_ptr + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 9'd1;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_bad       <= '0;
            r_unsorted  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_unsorted  <= |(r_bad & w_in_use);
            if (i_cfg.valid) begin
                r_count <= i_cfg.bucket_count;
            end
            // An entry is out of order when its base is not above the one below.
            if (r_state == S_LD_NEXT) begin
                r_bad[r_idx[LW-1:0]] <= 1'b0;
                if (9'(r_idx) < 9'(MAX_BUCKETS - 1)) begin
                    r_bad[w_nx_addr] <= (r_rdata <= r_base);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_base    <= n_base;
        r_val     <= n_val;
        r_lo      <= n_lo;
        r_lo_base <= n_lo_base;
        r_cand    <= n_cand;
        r_bit     <= n_bit;
        r_off     <= n_off;
        r_wo      <= n_wo;
        r_res     <= n_res;
        r_num     <= n_num;
        r_ptr     <= n_ptr;
        r_out     <= n_out;
    end

    // Base table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LD_NEXT) begin
            r_table[r_idx[LW-1:0]] <= r_base;
        end
        r_rdata <= r_table[w_raddr];
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.stream_sel       = r_out.stream_sel;
    assign o_out.out_byte         = r_out.out_byte;
    assign o_out.byte_valid       = r_out.byte_valid;
    assign o_out.run_last         = r_out.run_last;
    assign o_out.spare_index_bits = r_out.spare_index_bits;
    assign o_out.status           = r_out.status;

endmodule

FILE: rtl/bose_packer.sv
// ----------------------------------------------------------------------------
// bose_packer
// Appends a bucket index and an offset to the two LSB-first bit streams and
// splits off the finished bytes.
// ----------------------------------------------------------------------------
module bose_packer import bose_pkg::*; (
    input  t_pending    i_pend,
    input  logic [7:0]  i_sel,
    input  logic [3:0]  i_sel_width,
    input  logic [15:0] i_offset,
    input  logic [4:0]  i_offset_width,
    output t_pack       o_pack
);

    logic [14:0] w_iacc;
    logic [3:0]  w_in;
    logic [14:0] w_irem;
    logic [22:0] w_oacc;
    logic [4:0]  w_on;
    logic [6:0]  w_orem;
    logic [1:0]  w_onum;

    assign w_iacc = 15'(i_pend.idx_bits) | (15'(i_sel) << i_pend.idx_count);
    assign w_in   = 4'(i_pend.idx_count) + i_sel_width;
    assign w_irem = w_in[3] ? (w_iacc >> 8) : w_iacc;

    assign w_oacc = 23'(i_pend.off_bits) | (23'(i_offset) << i_pend.off_count);
    assign w_on   = 5'(i_pend.off_count) + i_offset_width;

    // At most 23 bits are held, so bit 4 of the count means two bytes.
    always_comb begin
        if (w_on[4]) begin
            w_onum = 2'd2;
            w_orem = w_oacc[22:16];
        end else if (w_on[3]) begin
            w_onum = 2'd1;
            w_orem = w_oacc[14:8];
        end else begin
            w_onum = 2'd0;
            w_orem = w_oacc[6:0];
        end
    end

    assign o_pack.idx_has        = w_in[3];
    assign o_pack.idx_byte       = w_iacc[7:0];
    assign o_pack.off_num        = w_onum;
    assign o_pack.off_byte0      = w_oacc[7:0];
    assign o_pack.off_byte1      = w_oacc[15:8];
    assign o_pack.next.idx_bits  = w_irem[6:0];
    assign o_pack.next.idx_count = w_in[2:0];
    assign o_pack.next.off_bits  = w_orem;
    assign o_pack.next.off_count = w_on[2:0];

endmodule

FILE: rtl/bose_checker.sv
// ----------------------------------------------------------------------------
// bose_checker
// Port-level checks of the bucket offset split encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bose_checker import bose_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_byte_valid,
    input logic       i_out_run_last,
    input logic [1:0] i_out_status
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled result changed or dropped");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an accepted request");

    // While a new request can be taken, only the last result of the previous
    // one may still wait.
    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_run_last)
        else $error("ready while results of a request are still due");

    // An error status comes alone, with no byte.
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> !i_out_byte_valid && i_out_run_last)
        else $error("error status with a byte or further results");

endmodule

bind bucket_offset_split_encoder_top bose_checker u_bose_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_byte_valid (o_out.byte_valid),
    .i_out_run_last   (o_out.run_last),
    .i_out_status     (o_out.status)
);

FILE: test/tb_bucket_offset_split_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bucket_offset_split_encoder_top
// Self-checking bench for the bucket offset split encoder. A scoreboard keeps
// its own copy of the base table, the bucket count and both partial stream
// bytes. It predicts the tagged bytes of every accepted request and compares
// them in order with the results taken from the block. The stimulus is a
// short directed sequence and then phases at several bucket counts. Some
// phases load an increasing table first; all mix encodes, finishes, good and
// bad loads and unknown requests, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_bucket_offset_split_encoder_top;
    import bose_pkg::*;

    localparam int          TABLE_DEPTH    = 256;
    localparam int          RESET_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 300;
    localparam logic [1:0]  REQ_UNKNOWN    = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

    class split_stream_scoreboard;
        logic [15:0] bases [TABLE_DEPTH];
        logic [8:0]  count_reg;
        logic [6:0]  index_tail;
        logic [2:0]  index_tail_len;
        logic [6:0]  offset_tail;
        logic [2:0]  offset_tail_len;
        t_result     awaited_results [$];
        int unsigned failures;

        function new();
            foreach (bases[i]) bases[i] = 16'h0000;
            count_reg       = 9'd1;
            index_tail      = '0;
            index_tail_len  = '0;
            offset_tail     = '0;
            offset_tail_len = '0;
            failures        = 0;
        endfunction

        function int unsigned used_count();
            int unsigned c;
            c = count_reg;
            if (c == 0) c = 1;
            if (c > TABLE_DEPTH) c = TABLE_DEPTH;
            return c;
        endfunction

        function int unsigned bits_needed(int unsigned n);
            int unsigned b;
            b = 0;
            while ((32'd1 << b) < n) b++;
            return b;
        endfunction

        function void add(logic sel, logic [7:0] data, logic valid, logic [2:0] spare,
                          logic [1:0] st);
            t_result r;
            r.stream_sel       = sel;
            r.out_byte         = data;
            r.byte_valid       = valid;
            r.run_last         = 1'b0;
            r.spare_index_bits = spare;
            r.status           = st;
            awaited_results.push_back(r);
        endfunction

        function void note_config(logic [8:0] value);
            count_reg = value;
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] idx, logic [15:0] base_v,
                                   logic [15:0] value);
            int unsigned cnt, sel, limit_v, acc, n, first, delta;
            logic [2:0]  spare;
            t_result     r;
            cnt   = used_count();
            first = awaited_results.size();
            case (req)
                REQ_LOAD: begin
                    if (idx >= cnt) begin
                        add(SEL_INDEX, 8'h00, 1'b0, 3'd0, ST_RANGE);
                    end else if (idx != 0 && base_v <= bases[idx - 1]) begin
                        add(SEL_INDEX, 8'h00, 1'b0, 3'd0, ST_ORDER);
                    end else begin
                        bases[idx] = base_v;
                        add(SEL_INDEX, 8'h00, 1'b0, 3'd0, ST_OK);
                    end
                end
                REQ_ENCODE: begin
                    if (value < bases[0]) begin
                        add(SEL_INDEX, 8'h00, 1'b0, 3'd0, ST_BELOW);
                    end else begin
                        // The highest bucket not above the value wins, even when the
                        // table is out of order.
                        sel = 0;
                        for (int j = 0; j < cnt; j++) begin
                            if (bases[j] <= value) sel = j;
                        end
                        limit_v = (sel + 1 >= cnt) ? VALUE_LIMIT : bases[sel + 1];
                        acc = index_tail | (sel << index_tail_len);
                        n   = index_tail_len + bits_needed(cnt);
                        while (n >= 8) begin
                            add(SEL_INDEX, 8'(acc), 1'b1, 3'd0, ST_OK);
                            acc = acc >> 8;
                            n   = n - 8;
                        end
                        index_tail     = 7'(acc);
                        index_tail_len = 3'(n);
                        delta = value - bases[sel];
                        acc   = offset_tail | (delta << offset_tail_len);
                        n     = offset_tail_len + bits_needed(limit_v - bases[sel]);
                        while (n >= 8) begin
                            add(SEL_OFFSET, 8'(acc), 1'b1, 3'd0, ST_OK);
                            acc = acc >> 8;
                            n   = n - 8;
                        end
                        offset_tail     = 7'(acc);
                        offset_tail_len = 3'(n);
                    end
                end
                REQ_FINISH: begin
                    spare = 3'd0 - index_tail_len;
                    if (index_tail_len != 0) begin
                        add(SEL_INDEX, {1'b0, index_tail}, 1'b1, spare, ST_OK);
                    end
                    if (offset_tail_len != 0) begin
                        add(SEL_OFFSET, {1'b0, offset_tail}, 1'b1, spare, ST_OK);
                    end
                    if (awaited_results.size() == first) begin
                        add(SEL_INDEX, 8'h00, 1'b0, spare, ST_OK);
                    end
                    index_tail      = '0;
                    index_tail_len  = '0;
                    offset_tail     = '0;
                    offset_tail_len = '0;
                end
                default: ;
            endcase
            if (awaited_results.size() == first) begin
                add(SEL_INDEX, 8'h00, 1'b0, 3'd0, ST_OK);
            end
            r = awaited_results.pop_back();
            r.run_last = 1'b1;
            awaited_results.push_back(r);
        endfunction

        function void report(string what, t_result want, t_result got);
            if (failures < 10) begin
                $display("%s: expected sel=%0d byte=%02h valid=%0d last=%0d spare=%0d st=%0d",
                         what, want.stream_sel, want.out_byte, want.byte_valid,
                         want.run_last, want.spare_index_bits, want.status);
                $display("    actual   sel=%0d byte=%02h valid=%0d last=%0d spare=%0d st=%0d",
                         got.stream_sel, got.out_byte, got.byte_valid, got.run_last,
                         got.spare_index_bits, got.status);
            end
            failures++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report("result with nothing awaited", '0, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.stream_sel !== want.stream_sel || got.out_byte !== want.out_byte ||
                got.byte_valid !== want.byte_valid || got.run_last !== want.run_last ||
                got.spare_index_bits !== want.spare_index_bits ||
                got.status !== want.status) begin
                report("result mismatch", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    idle_t       idle_mode;
    int unsigned hold_request;

    split_stream_scoreboard sb = new();

    bose_in_if  in_bus ();
    bose_cfg_if cfg_bus ();
    bose_out_if out_bus ();

    bucket_offset_split_encoder_top #(
        .MAX_BUCKETS (TABLE_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 67;
            IDLE_BOTH:   return $urandom_range(0, 99) < 31;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 67;
            IDLE_BOTH:     return $urandom_range(0, 99) < 31;
            default:       return 1'b0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests keep it asserted.
    task automatic send_req(logic [1:0] req, logic [7:0] idx, logic [15:0] base_v,
                            logic [15:0] value);
        while (sender_pauses()) begin
            in_bus.valid = 1'b0;
            @(negedge clk);
        end
        in_bus.valid        = 1'b1;
        in_bus.req_type     = req;
        in_bus.entry_index  = idx;
        in_bus.entry_base   = base_v;
        in_bus.sample_value = value;
        do @(posedge clk); while (in_bus.ready !== 1'b1);
        sb.note_request(req, idx, base_v, value);
        @(negedge clk);
    endtask

    task automatic write_count(logic [8:0] value);
        cfg_bus.valid        = 1'b1;
        cfg_bus.bucket_count = value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        sb.note_config(value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic wait_drained();
        in_bus.valid = 1'b0;
        while (sb.awaited_results.size() != 0) @(negedge clk);
    endtask

    // Loads entries 0..c-1 with strictly increasing bases, either spread over
    // the whole value range or packed tightly with narrow spans.
    task automatic load_table(int unsigned c);
        int unsigned step, start;
        if ($urandom_range(0, 2) == 0) begin
            step  = $urandom_range(1, 8);
            start = $urandom_range(0, 65536 - c * step);
        end else begin
            step  = 65536 / c;
            start = 0;
        end
        for (int j = 0; j < c; j++) begin
            send_req(REQ_LOAD, 8'(j), 16'(start + j * step + $urandom_range(0, step - 1)),
                     16'($urandom));
        end
    endtask

    task automatic run_random(int unsigned n);
        int unsigned cnt, pick, j, lo, hi;
        logic [15:0] value;
        logic [7:0]  idx;
        logic [15:0] base_v;
        for (int i = 0; i < n; i++) begin
            cnt  = sb.used_count();
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                j    = $urandom_range(0, cnt - 1);
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    lo = sb.bases[j];
                    hi = (j + 1 < cnt && sb.bases[j + 1] > sb.bases[j]) ?
                         sb.bases[j + 1] - 1 : 65535;
                    value = 16'($urandom_range(hi, lo));
                end else if (pick < 8) begin
                    value = 16'($urandom);
                end else if (pick == 8) begin
                    value = (sb.bases[0] != 0) ? 16'($urandom_range(sb.bases[0] - 1, 0))
                                               : 16'h0000;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       value = 16'h0000;
                        1:       value = 16'hFFFF;
                        default: value = sb.bases[j];
                    endcase
                end
                send_req(REQ_ENCODE, 8'($urandom), 16'($urandom), value);
            end else if (pick < 74) begin
                send_req(REQ_FINISH, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                pick   = $urandom_range(0, 9);
                base_v = 16'($urandom);
                if (pick < 3 && cnt < TABLE_DEPTH) begin
                    idx = 8'($urandom_range(TABLE_DEPTH - 1, cnt));
                end else if (pick < 6 && cnt >= 2) begin
                    idx    = 8'($urandom_range(cnt - 1, 1));
                    base_v = 16'($urandom_range(sb.bases[idx - 1], 0));
                end else if (pick < 9) begin
                    // Rewrites an entry above its lower neighbor; this may leave the
                    // table out of order against the entry above.
                    idx = 8'($urandom_range(cnt - 1, 0));
                    lo  = (idx == 0) ? 0 : sb.bases[idx - 1] + 1;
                    if (lo > 65535) lo = 65535;
                    base_v = 16'($urandom_range(65535, lo));
                end else begin
                    idx = 8'($urandom);
                end
                send_req(REQ_LOAD, idx, base_v, 16'($urandom));
            end else begin
                send_req(REQ_UNKNOWN, 8'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic run_phase(logic [8:0] setting, idle_t mode, bit rebuild,
                             int unsigned n, int unsigned hold);
        wait_drained();
        write_count(setting);
        idle_mode    = mode;
        hold_request = hold;
        if (rebuild) load_table(sb.used_count());
        run_random(n);
    endtask

    // Result side: samples at the rising edge and moves ready at the falling
    // edge, including the long hold-off that backs the block up.
    initial begin
        t_result     got;
        int unsigned hold_left;
        hold_left     = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                got.stream_sel       = out_bus.stream_sel;
                got.out_byte         = out_bus.out_byte;
                got.byte_valid       = out_bus.byte_valid;
                got.run_last         = out_bus.run_last;
                got.spare_index_bits = out_bus.spare_index_bits;
                got.status           = out_bus.status;
                sb.check_result(got);
            end
            @(negedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                out_bus.ready = 1'b0;
                hold_left--;
            end else begin
                out_bus.ready = !receiver_stalls();
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
                (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_bucket_offset_split_encoder_top NOT OK");
        $finish;
    end

    initial begin
        rst_n                = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.req_type      = REQ_LOAD;
        in_bus.entry_index   = 8'h00;
        in_bus.entry_base    = 16'h0000;
        in_bus.sample_value  = 16'h0000;
        cfg_bus.valid        = 1'b0;
        cfg_bus.bucket_count = 9'd0;
        idle_mode            = IDLE_NONE;
        hold_request         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One bucket after reset: no index bits, a full 16-bit offset.
        send_req(REQ_LOAD,   8'd1,   16'd5,     16'h0000);
        send_req(REQ_LOAD,   8'd0,   16'h0000,  16'h0000);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'h0000);
        send_req(REQ_ENCODE, 8'hFF,  16'hFFFF,  16'hFFFF);
        send_req(REQ_LOAD,   8'd0,   16'h8000,  16'h0000);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'h7FFF);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'h8001);
        send_req(REQ_FINISH, 8'h00,  16'h0000,  16'h0000);
        send_req(REQ_FINISH, 8'h00,  16'h0000,  16'h0000);
        send_req(REQ_UNKNOWN, 8'hFF, 16'hFFFF,  16'hFFFF);
        send_req(REQ_LOAD,   8'd255, 16'hFFFF,  16'h0000);

        // Three buckets: a rejected non-increasing load, a last bucket of span
        // one, then an entry 0 rewrite that leaves the table out of order.
        wait_drained();
        write_count(9'd3);
        send_req(REQ_LOAD,   8'd0,   16'd10,    16'h0000);
        send_req(REQ_LOAD,   8'd1,   16'd20,    16'h0000);
        send_req(REQ_LOAD,   8'd2,   16'd20,    16'h0000);
        send_req(REQ_LOAD,   8'd2,   16'hFFFF,  16'h0000);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'd15);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'hFFFF);
        send_req(REQ_LOAD,   8'd0,   16'd30,    16'h0000);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'd25);
        send_req(REQ_ENCODE, 8'h00,  16'h0000,  16'd40);
        send_req(REQ_LOAD,   8'd3,   16'h1234,  16'h0000);
        send_req(REQ_FINISH, 8'h00,  16'h0000,  16'h0000);

        run_phase(9'd511, IDLE_NONE, 1'b1, 35, 0);
        run_phase(9'd0, IDLE_SENDER, 1'b0, 25, 0);
        run_phase(9'd2, IDLE_RECEIVER, 1'b1, 35, 0);
        run_phase(9'd256, IDLE_BOTH, 1'b0, 35, 0);
        run_phase(9'($urandom_range(24, 3)), IDLE_NONE, 1'b1, 45, 400);
        run_phase(9'd1, IDLE_RECEIVER, 1'b1, 25, 0);
        run_phase(9'($urandom_range(120, 25)), IDLE_SENDER, 1'b1, 45, 0);
        run_phase(9'd257, IDLE_BOTH, 1'b0, 35, 0);
        run_phase(9'($urandom_range(16, 2)), IDLE_NONE, 1'b1, 45, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.awaited_results.size() != 0) begin
            $display("%0d awaited results never arrived", sb.awaited_results.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("tb_bucket_offset_split_encoder_top OK");
        end else begin
            $display("tb_bucket_offset_split_encoder_top NOT OK");
        end
        $finish;
    end

endmodule
